FILE: rtl/rmsfl_pkg.sv
// rmsfl_pkg: shared types and constants of the run mode sequencer
// mode and message codes, register indexes, reset values, control/status structs
// no dependencies
package rmsfl_pkg;

	// mode codes
	localparam logic [1:0] MODE_BOOT    = 2'd0;
	localparam logic [1:0] MODE_READY   = 2'd1;
	localparam logic [1:0] MODE_RUNNING = 2'd2;
	localparam logic [1:0] MODE_FAULT   = 2'd3;

	// message codes
	localparam logic [2:0] MSG_BOOTING     = 3'd0;
	localparam logic [2:0] MSG_READY       = 3'd1;
	localparam logic [2:0] MSG_ACTIVE      = 3'd2;
	localparam logic [2:0] MSG_RECOVERING  = 3'd3;
	localparam logic [2:0] MSG_UNAVAILABLE = 3'd4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIME     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_TIME = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM    = 3'd6;

	// register reset values
	localparam logic [31:0] BOOT_TIME_RST     = 32'd500;
	localparam logic [31:0] RECOVERY_TIME_RST = 32'd500;
	localparam logic [15:0] TICK_PERIOD_RST   = 16'd100;
	localparam logic [11:0] BOX_LEFT_RST      = 12'd60;
	localparam logic [11:0] BOX_RIGHT_RST     = 12'd260;
	localparam logic [11:0] BOX_TOP_RST       = 12'd175;
	localparam logic [11:0] BOX_BOTTOM_RST    = 12'd230;

	// divider: one quotient bit per step
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // item accepted, update mode state
		logic div_init;  // start dividing elapsed time by the tick period
		logic div_step;  // one quotient bit
		logic out_load;  // commit ticks and load the result register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic need_div;  // running with at least one whole period elapsed
	} status_t;

endpackage

FILE: rtl/rmsfl_ctrl.sv
// rmsfl_ctrl: sequencing state machine for one item at a time
// drives datapath commands, owns the input ready and the result valid
// depends on rmsfl_pkg
module rmsfl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rmsfl_pkg::status_t  status,
	output rmsfl_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [rmsfl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (status.need_div) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == rmsfl_pkg::DIV_CNT_W'(rmsfl_pkg::DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/rmsfl_dp.sv
// rmsfl_dp: configuration registers, mode state, tick divider and result register
// acts on commands from rmsfl_ctrl
// depends on rmsfl_pkg
module rmsfl_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rmsfl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic [31:0]                         now_time,
	input  logic                                sensor_ok,
	input  logic                                touch_pressed,
	input  logic [11:0]                         touch_x,
	input  logic [11:0]                         touch_y,
	input  rmsfl_pkg::cmd_t                     cmd,
	output rmsfl_pkg::status_t                  status,
	output logic [1:0]                          mode,
	output logic                                btn_enable,
	output logic [2:0]                          message_code,
	output logic [31:0]                         tick_total
);

	// configuration
	logic [31:0] boot_time_q;
	logic [31:0] recovery_time_q;
	logic [15:0] tick_period_q;
	logic [11:0] box_left_q;
	logic [11:0] box_right_q;
	logic [11:0] box_top_q;
	logic [11:0] box_bottom_q;

	// block state
	logic [1:0]  mode_q;
	logic [31:0] rec_start_q;
	logic        was_pressed_q;
	logic [31:0] last_tick_q;
	logic [31:0] tick_count_q;

	// item held while dividing
	logic [31:0] now_q;
	logic        ok_q;

	// divider
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic        div_done_q;
	logic [16:0] trial;
	logic        trial_ge;

	// mode update terms
	logic [1:0]  mode_d;
	logic [31:0] rec_start_d;
	logic        start_run;
	logic        in_box;
	logic        press_edge;
	logic [31:0] rec_elapsed;
	logic [31:0] run_elapsed;
	logic [31:0] tick_next;
	logic        en_d;
	logic [2:0]  msg_d;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_time_q <= rmsfl_pkg::BOOT_TIME_RST;
			recovery_time_q <= rmsfl_pkg::RECOVERY_TIME_RST;
			tick_period_q <= rmsfl_pkg::TICK_PERIOD_RST;
			box_left_q <= rmsfl_pkg::BOX_LEFT_RST;
			box_right_q <= rmsfl_pkg::BOX_RIGHT_RST;
			box_top_q <= rmsfl_pkg::BOX_TOP_RST;
			box_bottom_q <= rmsfl_pkg::BOX_BOTTOM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rmsfl_pkg::REG_BOOT_TIME:     boot_time_q <= cfg_data;
				rmsfl_pkg::REG_RECOVERY_TIME: recovery_time_q <= cfg_data;
				rmsfl_pkg::REG_TICK_PERIOD:   tick_period_q <= cfg_data[15:0];
				rmsfl_pkg::REG_BOX_LEFT:      box_left_q <= cfg_data[11:0];
				rmsfl_pkg::REG_BOX_RIGHT:     box_right_q <= cfg_data[11:0];
				rmsfl_pkg::REG_BOX_TOP:       box_top_q <= cfg_data[11:0];
				rmsfl_pkg::REG_BOX_BOTTOM:    box_bottom_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// health, recovery, boot and button toggle from the accepted item
	always_comb begin
		rec_elapsed = now_time - rec_start_q;
		in_box = (touch_x >= box_left_q) && (touch_x <= box_right_q) &&
			(touch_y >= box_top_q) && (touch_y <= box_bottom_q);
		press_edge = touch_pressed && !was_pressed_q;
		mode_d = mode_q;
		rec_start_d = rec_start_q;
		start_run = 1'b0;
		if (!sensor_ok) begin
			mode_d = rmsfl_pkg::MODE_FAULT;
			rec_start_d = '0;
		end else if (mode_q == rmsfl_pkg::MODE_FAULT) begin
			if (rec_start_q == '0) begin
				rec_start_d = now_time;
			end else if (rec_elapsed >= recovery_time_q) begin
				mode_d = rmsfl_pkg::MODE_READY;
				rec_start_d = '0;
			end
		end else if (mode_q == rmsfl_pkg::MODE_BOOT && now_time >= boot_time_q) begin
			mode_d = rmsfl_pkg::MODE_READY;
		end
		if (press_edge && sensor_ok && in_box) begin
			if (mode_d == rmsfl_pkg::MODE_READY) begin
				mode_d = rmsfl_pkg::MODE_RUNNING;
				start_run = 1'b1;
			end else if (mode_d == rmsfl_pkg::MODE_RUNNING) begin
				mode_d = rmsfl_pkg::MODE_READY;
			end
		end
	end

	// whole periods are counted only while running
	assign run_elapsed = now_q - last_tick_q;
	assign status.need_div = (mode_q == rmsfl_pkg::MODE_RUNNING) && (tick_period_q != '0) &&
		(run_elapsed >= {16'd0, tick_period_q});

	// restoring divider step
	assign trial = {rem_q, dvd_q[31]};
	assign trial_ge = trial >= {1'b0, tick_period_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_time;
			ok_q <= sensor_ok;
		end
		if (cmd.div_init) begin
			dvd_q <= run_elapsed;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial_ge) begin
				rem_q <= 16'(trial - {1'b0, tick_period_q});
				dvd_q <= {dvd_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				dvd_q <= {dvd_q[30:0], 1'b0};
			end
		end
	end

	// tick total and result fields
	assign tick_next = div_done_q ? (tick_count_q + dvd_q) : tick_count_q;

	always_comb begin
		case (mode_q)
			rmsfl_pkg::MODE_BOOT: begin
				en_d = 1'b0;
				msg_d = rmsfl_pkg::MSG_BOOTING;
			end
			rmsfl_pkg::MODE_READY: begin
				en_d = 1'b1;
				msg_d = rmsfl_pkg::MSG_READY;
			end
			rmsfl_pkg::MODE_RUNNING: begin
				en_d = 1'b1;
				msg_d = rmsfl_pkg::MSG_ACTIVE;
			end
			default: begin
				en_d = 1'b0;
				msg_d = ok_q ? rmsfl_pkg::MSG_RECOVERING : rmsfl_pkg::MSG_UNAVAILABLE;
			end
		endcase
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rmsfl_pkg::MODE_BOOT;
			rec_start_q <= '0;
			was_pressed_q <= 1'b0;
			last_tick_q <= '0;
			tick_count_q <= '0;
			div_done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				mode_q <= mode_d;
				rec_start_q <= rec_start_d;
				was_pressed_q <= touch_pressed;
				div_done_q <= 1'b0;
				if (start_run) begin
					last_tick_q <= now_time;
				end
			end else if (cmd.div_init) begin
				div_done_q <= 1'b1;
			end else if (cmd.out_load && div_done_q) begin
				// last + q * period equals now - remainder
				tick_count_q <= tick_next;
				last_tick_q <= now_q - {16'd0, rem_q};
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mode <= mode_q;
			btn_enable <= en_d;
			message_code <= msg_d;
			tick_total <= tick_next;
		end
	end

endmodule

FILE: rtl/run_mode_sequencer_with_fault_lockout.sv
// run_mode_sequencer_with_fault_lockout: top level of the run mode sequencer
// joins rmsfl_ctrl and rmsfl_dp
// depends on rmsfl_pkg, rmsfl_ctrl, rmsfl_dp
//
// usage
// - input channel (in_valid/in_ready) takes one time-stamped update: now_time,
//   sensor_ok, touch_pressed, touch_x, touch_y
// - output channel (out_valid/out_ready) gives one result per update: mode,
//   btn_enable, message_code, tick_total
// - configuration is a plain write port (cfg_we, cfg_index, cfg_data), written
//   while the block is idle; indexes past the last register are ignored
// - one item at a time: an accepted update passes a calc step, then a done step
//   that loads the result register; while running with a whole tick period
//   elapsed the 32 step restoring divider runs between those two steps
// - in_ready is high only between items; the result sits in an output register,
//   so the next item is accepted while it waits, and that item holds in its
//   final step until the register frees up
// - reset puts the block in boot with zero ticks and the registers at their
//   default values; no item is in flight afterwards
module run_mode_sequencer_with_fault_lockout (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rmsfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [31:0]                      now_time,
	input  logic                             sensor_ok,
	input  logic                             touch_pressed,
	input  logic [11:0]                      touch_x,
	input  logic [11:0]                      touch_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       mode,
	output logic                             btn_enable,
	output logic [2:0]                       message_code,
	output logic [31:0]                      tick_total
);

	rmsfl_pkg::cmd_t    cmd;
	rmsfl_pkg::status_t status;

	// sequencing
	rmsfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// state and arithmetic
	rmsfl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.now_time       (now_time),
		.sensor_ok      (sensor_ok),
		.touch_pressed  (touch_pressed),
		.touch_x        (touch_x),
		.touch_y        (touch_y),
		.cmd            (cmd),
		.status         (status),
		.mode           (mode),
		.btn_enable     (btn_enable),
		.message_code   (message_code),
		.tick_total     (tick_total)
	);

endmodule

FILE: rtl/rmsfl_chk.sv
// rmsfl_chk: port level checks of the run mode sequencer
// bound to run_mode_sequencer_with_fault_lockout
// depends on rmsfl_pkg
module rmsfl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  mode,
	input logic        btn_enable,
	input logic [2:0]  message_code,
	input logic [31:0] tick_total
);

	// a stalled result holds
	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(tick_total) &&
			$stable(message_code);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

	// one item at a time: busy right after an accept
	property p_busy;
		@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready;
	endproperty
	a_busy: assert property (p_busy) else $error("item accepted while busy");

	// button enable follows the mode
	property p_enable;
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> btn_enable ==
			(mode == rmsfl_pkg::MODE_READY || mode == rmsfl_pkg::MODE_RUNNING);
	endproperty
	a_enable: assert property (p_enable) else $error("button enable disagrees with mode");

	// fault mode reports recovering or unavailable
	property p_fault_msg;
		@(posedge clk) disable iff (!arst_n)
		out_valid && mode == rmsfl_pkg::MODE_FAULT |->
			message_code == rmsfl_pkg::MSG_RECOVERING ||
			message_code == rmsfl_pkg::MSG_UNAVAILABLE;
	endproperty
	a_fault_msg: assert property (p_fault_msg) else $error("bad message in fault mode");

endmodule

bind run_mode_sequencer_with_fault_lockout rmsfl_chk u_rmsfl_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.mode           (mode),
	.btn_enable     (btn_enable),
	.message_code   (message_code),
	.tick_total     (tick_total)
);

FILE: test/rmsfl_result_checker.sv
`timescale 1ns / 100ps
// rmsfl_result_checker: watches the config port and both item channels of the
// run mode sequencer, predicts each result and compares it field by field
// depends on rmsfl_pkg
module rmsfl_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rmsfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [31:0]                      now_time,
	input  logic                             sensor_ok,
	input  logic                             touch_pressed,
	input  logic [11:0]                      touch_x,
	input  logic [11:0]                      touch_y,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [1:0]                       mode,
	input  logic                             btn_enable,
	input  logic [2:0]                       message_code,
	input  logic [31:0]                      tick_total,
	output int                               error_count,
	output int                               pending_count
);

	typedef struct packed {
		logic [1:0]  mode;
		logic        button_en;
		logic [2:0]  msg;
		logic [31:0] ticks;
	} seq_result_t;

	seq_result_t expected_results[$];
	int mismatches = 0;

	// shadow copy of the settings
	logic [31:0] boot_at      = rmsfl_pkg::BOOT_TIME_RST;
	logic [31:0] recover_ms   = rmsfl_pkg::RECOVERY_TIME_RST;
	logic [15:0] tick_ms      = rmsfl_pkg::TICK_PERIOD_RST;
	logic [11:0] btn_x_lo     = rmsfl_pkg::BOX_LEFT_RST;
	logic [11:0] btn_x_hi     = rmsfl_pkg::BOX_RIGHT_RST;
	logic [11:0] btn_y_lo     = rmsfl_pkg::BOX_TOP_RST;
	logic [11:0] btn_y_hi     = rmsfl_pkg::BOX_BOTTOM_RST;

	// predicted sequencer state
	logic [1:0]  cur_mode     = rmsfl_pkg::MODE_BOOT;
	logic [31:0] heal_stamp   = '0;
	logic        was_touched  = 1'b0;
	logic [31:0] tick_base    = '0;
	logic [31:0] ticks_run    = '0;

	task automatic take_setting(input logic [rmsfl_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		case (idx)
			rmsfl_pkg::REG_BOOT_TIME:     boot_at = data;
			rmsfl_pkg::REG_RECOVERY_TIME: recover_ms = data;
			rmsfl_pkg::REG_TICK_PERIOD:   tick_ms = data[15:0];
			rmsfl_pkg::REG_BOX_LEFT:      btn_x_lo = data[11:0];
			rmsfl_pkg::REG_BOX_RIGHT:     btn_x_hi = data[11:0];
			rmsfl_pkg::REG_BOX_TOP:       btn_y_lo = data[11:0];
			rmsfl_pkg::REG_BOX_BOTTOM:    btn_y_hi = data[11:0];
			default: ;
		endcase
	endtask

	// advance the mode state by one update and form its result
	task automatic advance_sequencer(input logic [31:0] now, input logic ok, input logic pr,
			input logic [11:0] x, input logic [11:0] y, output seq_result_t res);
		logic        press_edge;
		logic        hit;
		logic [31:0] since;
		logic [31:0] whole;
		// health and timed transitions
		if (!ok) begin
			cur_mode = rmsfl_pkg::MODE_FAULT;
			heal_stamp = '0;
		end else if (cur_mode == rmsfl_pkg::MODE_FAULT) begin
			since = now - heal_stamp;
			if (heal_stamp == '0) begin
				heal_stamp = now;
			end else if (since >= recover_ms) begin
				cur_mode = rmsfl_pkg::MODE_READY;
				heal_stamp = '0;
			end
		end else if (cur_mode == rmsfl_pkg::MODE_BOOT && now >= boot_at) begin
			cur_mode = rmsfl_pkg::MODE_READY;
		end
		// start/stop button on a press edge
		press_edge = pr && !was_touched;
		was_touched = pr;
		hit = x >= btn_x_lo && x <= btn_x_hi && y >= btn_y_lo && y <= btn_y_hi;
		if (press_edge && ok && hit) begin
			if (cur_mode == rmsfl_pkg::MODE_READY) begin
				cur_mode = rmsfl_pkg::MODE_RUNNING;
				tick_base = now;
			end else if (cur_mode == rmsfl_pkg::MODE_RUNNING) begin
				cur_mode = rmsfl_pkg::MODE_READY;
			end
		end
		// whole tick periods while running
		if (cur_mode == rmsfl_pkg::MODE_RUNNING && tick_ms != '0) begin
			since = now - tick_base;
			if (since >= {16'd0, tick_ms}) begin
				whole = since / {16'd0, tick_ms};
				ticks_run = ticks_run + whole;
				tick_base = tick_base + whole * {16'd0, tick_ms};
			end
		end
		res.mode = cur_mode;
		res.ticks = ticks_run;
		case (cur_mode)
			rmsfl_pkg::MODE_BOOT: begin
				res.button_en = 1'b0;
				res.msg = rmsfl_pkg::MSG_BOOTING;
			end
			rmsfl_pkg::MODE_READY: begin
				res.button_en = 1'b1;
				res.msg = rmsfl_pkg::MSG_READY;
			end
			rmsfl_pkg::MODE_RUNNING: begin
				res.button_en = 1'b1;
				res.msg = rmsfl_pkg::MSG_ACTIVE;
			end
			default: begin
				res.button_en = 1'b0;
				res.msg = ok ? rmsfl_pkg::MSG_RECOVERING : rmsfl_pkg::MSG_UNAVAILABLE;
			end
		endcase
	endtask

	task automatic compare_result(input seq_result_t exp_r);
		if (mode !== exp_r.mode) begin
			$display("%0t: mode expected %0d actual %0d", $time, exp_r.mode, mode);
			mismatches++;
		end
		if (btn_enable !== exp_r.button_en) begin
			$display("%0t: btn_enable expected %0d actual %0d", $time,
				exp_r.button_en, btn_enable);
			mismatches++;
		end
		if (message_code !== exp_r.msg) begin
			$display("%0t: message_code expected %0d actual %0d", $time,
				exp_r.msg, message_code);
			mismatches++;
		end
		if (tick_total !== exp_r.ticks) begin
			$display("%0t: tick_total expected %0d actual %0d", $time,
				exp_r.ticks, tick_total);
			mismatches++;
		end
	endtask

	// watch the ports; results are compared before the new item is predicted
	always @(posedge clk or negedge arst_n) begin
		seq_result_t r;
		if (!arst_n) begin
			boot_at = rmsfl_pkg::BOOT_TIME_RST;
			recover_ms = rmsfl_pkg::RECOVERY_TIME_RST;
			tick_ms = rmsfl_pkg::TICK_PERIOD_RST;
			btn_x_lo = rmsfl_pkg::BOX_LEFT_RST;
			btn_x_hi = rmsfl_pkg::BOX_RIGHT_RST;
			btn_y_lo = rmsfl_pkg::BOX_TOP_RST;
			btn_y_hi = rmsfl_pkg::BOX_BOTTOM_RST;
			cur_mode = rmsfl_pkg::MODE_BOOT;
			heal_stamp = '0;
			was_touched = 1'b0;
			tick_base = '0;
			ticks_run = '0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we)
				take_setting(cfg_index, cfg_data);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, mode %0d ticks %0d", $time,
						mode, tick_total);
					mismatches++;
				end else begin
					compare_result(expected_results.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				advance_sequencer(now_time, sensor_ok, touch_pressed, touch_x, touch_y, r);
				expected_results.push_back(r);
			end
		end
		error_count <= mismatches;
		pending_count <= expected_results.size();
	end

endmodule

FILE: test/run_mode_sequencer_with_fault_lockout_tb.sv
`timescale 1ns / 100ps
// run_mode_sequencer_with_fault_lockout_tb: stimulus and verdict for the run mode sequencer
// depends on rmsfl_pkg, run_mode_sequencer_with_fault_lockout and rmsfl_result_checker
module run_mode_sequencer_with_fault_lockout_tb;

	localparam logic [rmsfl_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [rmsfl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                     cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [31:0]                     now_time = '0;
	logic                            sensor_ok = 1'b0;
	logic                            touch_pressed = 1'b0;
	logic [11:0]                     touch_x = '0;
	logic [11:0]                     touch_y = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [1:0]                      mode;
	logic                            btn_enable;
	logic [2:0]                      message_code;
	logic [31:0]                     tick_total;

	int result_errors;
	int results_owed;

	// stimulus state
	bit          steady = 1'b0;
	logic [11:0] x_lo = rmsfl_pkg::BOX_LEFT_RST;
	logic [11:0] x_hi = rmsfl_pkg::BOX_RIGHT_RST;
	logic [11:0] y_lo = rmsfl_pkg::BOX_TOP_RST;
	logic [11:0] y_hi = rmsfl_pkg::BOX_BOTTOM_RST;
	logic [31:0] clock_ms = '0;
	logic        finger_down = 1'b0;
	int          sensor_outage = 0;
	int          stall_left = 0;

	run_mode_sequencer_with_fault_lockout u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.now_time(now_time), .sensor_ok(sensor_ok), .touch_pressed(touch_pressed),
		.touch_x(touch_x), .touch_y(touch_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.mode(mode), .btn_enable(btn_enable), .message_code(message_code),
		.tick_total(tick_total)
	);

	rmsfl_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.now_time(now_time), .sensor_ok(sensor_ok), .touch_pressed(touch_pressed),
		.touch_x(touch_x), .touch_y(touch_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.mode(mode), .btn_enable(btn_enable), .message_code(message_code),
		.tick_total(tick_total),
		.error_count(result_errors), .pending_count(results_owed)
	);

	always #1 clk = ~clk;

	// result side: random stall bursts between ready stretches
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(1, 16) - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= $urandom_range(0, 24);
		end
	end

	// one update item, with an optional idle burst ahead of it
	task automatic send_update(input logic [31:0] t, input logic ok, input logic pr,
			input logic [11:0] x, input logic [11:0] y);
		if (!steady && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_time <= t;
		sensor_ok <= ok;
		touch_pressed <= pr;
		touch_x <= x;
		touch_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and wait until every result is back
	task automatic drain_results;
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic put_reg(input logic [rmsfl_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// pick the settings of one phase, extremes on fixed phases
	task automatic program_phase(input int phase);
		logic [31:0] boot_v;
		logic [31:0] rec_v;
		logic [15:0] per_v;
		logic [11:0] l, r, t, b;
		boot_v = $urandom;
		rec_v = $urandom_range(0, 2500);
		per_v = 16'($urandom_range(1, 400));
		l = 12'($urandom_range(0, 3500));
		r = l + 12'($urandom_range(0, 595));
		t = 12'($urandom_range(0, 3500));
		b = t + 12'($urandom_range(0, 595));
		case (phase)
			1: begin
				per_v = 16'd0;
				boot_v = 32'd0;
				l = 12'd0;
				r = 12'hFFF;
				t = 12'd0;
				b = 12'hFFF;
			end
			2: begin
				per_v = 16'd1;
				rec_v = 32'd0;
				r = l;
				b = t;
			end
			3: begin
				per_v = 16'hFFFF;
				rec_v = 32'hFFFF_FFFF;
			end
			4: begin
				boot_v = 32'hFFFF_FFFF;
				l = 12'd2000;
				r = 12'd1999;
			end
			5: begin
				t = 12'hFFF;
				b = 12'd0;
			end
			default: ;
		endcase
		put_reg(rmsfl_pkg::REG_BOOT_TIME, boot_v);
		put_reg(rmsfl_pkg::REG_RECOVERY_TIME, rec_v);
		put_reg(rmsfl_pkg::REG_TICK_PERIOD, {16'($urandom_range(0, 16'hFFFF)), per_v});
		put_reg(rmsfl_pkg::REG_BOX_LEFT, {20'($urandom_range(0, 20'hFFFFF)), l});
		put_reg(rmsfl_pkg::REG_BOX_RIGHT, {20'($urandom_range(0, 20'hFFFFF)), r});
		put_reg(rmsfl_pkg::REG_BOX_TOP, {20'($urandom_range(0, 20'hFFFFF)), t});
		put_reg(rmsfl_pkg::REG_BOX_BOTTOM, {20'($urandom_range(0, 20'hFFFFF)), b});
		put_reg(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
		x_lo = l;
		x_hi = r;
		y_lo = t;
		y_hi = b;
	endtask

	// mostly advancing time with touch sessions, some jumps, outages and noise
	task automatic drive_random_updates(input int count);
		logic        ok;
		logic        pr;
		logic [11:0] x, y;
		int          pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				clock_ms = $urandom;
			else if (pick < 5)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
			else if (pick < 7)
				clock_ms = 32'd0;
			else
				clock_ms = clock_ms + $urandom_range(0, 350);
			// sensor outages in short bursts
			if (sensor_outage > 0) begin
				ok = 1'b0;
				sensor_outage--;
			end else if ($urandom_range(0, 39) == 0) begin
				ok = 1'b0;
				sensor_outage = $urandom_range(0, 3);
			end else begin
				ok = 1'b1;
			end
			// touch: presses land in the button most of the time
			if (finger_down)
				pr = 1'($urandom_range(0, 1));
			else
				pr = ($urandom_range(0, 2) == 0);
			if (pr && !finger_down && x_lo <= x_hi && y_lo <= y_hi
					&& $urandom_range(0, 4) != 0) begin
				x = 12'($urandom_range(x_lo, x_hi));
				y = 12'($urandom_range(y_lo, y_hi));
			end else begin
				x = 12'($urandom_range(0, 4095));
				y = 12'($urandom_range(0, 4095));
			end
			if (pick >= 95) begin
				ok = 1'($urandom_range(0, 1));
				pr = 1'($urandom_range(0, 1));
			end
			finger_down = pr;
			send_update(clock_ms, ok, pr, x, y);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// boot exit, button edges, tick counting, fault and recovery, wrap
		send_update(32'd0, 1'b1, 1'b0, 12'd0, 12'd0);
		send_update(32'd499, 1'b1, 1'b1, 12'd60, 12'd175);
		send_update(32'd500, 1'b1, 1'b0, 12'd60, 12'd175);
		send_update(32'd510, 1'b1, 1'b1, 12'd261, 12'd200);
		send_update(32'd520, 1'b1, 1'b0, 12'd261, 12'd200);
		send_update(32'd530, 1'b1, 1'b1, 12'd150, 12'd174);
		send_update(32'd540, 1'b1, 1'b0, 12'd150, 12'd174);
		send_update(32'd600, 1'b1, 1'b1, 12'd60, 12'd175);
		send_update(32'd699, 1'b1, 1'b1, 12'd260, 12'd230);
		send_update(32'd700, 1'b1, 1'b0, 12'd0, 12'd0);
		send_update(32'd1050, 1'b1, 1'b0, 12'd0, 12'd0);
		send_update(32'd1060, 1'b0, 1'b1, 12'd100, 12'd200);
		// healthy stamp of zero leaves recovery unstarted
		send_update(32'd0, 1'b1, 1'b0, 12'd100, 12'd200);
		send_update(32'd10, 1'b1, 1'b0, 12'd100, 12'd200);
		send_update(32'd509, 1'b1, 1'b0, 12'd100, 12'd200);
		send_update(32'd510, 1'b1, 1'b0, 12'd100, 12'd200);
		// run across the time wrap
		send_update(32'hFFFF_FF00, 1'b1, 1'b1, 12'd260, 12'd230);
		send_update(32'h0000_0100, 1'b1, 1'b0, 12'hFFF, 12'hFFF);
		send_update(32'hFFFF_FFFF, 1'b1, 1'b1, 12'hFFF, 12'hFFF);
		send_update(32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0, 12'd0);
		send_update(32'hFFFF_FFFF, 1'b1, 1'b1, 12'd100, 12'd200);
		send_update(32'hFFFF_FFFF, 1'b0, 1'b0, 12'hFFF, 12'hFFF);
		drain_results();

		// random phases, each under new settings; the last one without idling
		for (int phase = 1; phase <= 8; phase++) begin
			steady = (phase == 8);
			program_phase(phase);
			drive_random_updates(150);
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (result_errors == 0 && results_owed == 0)
			$display("run_mode_sequencer_with_fault_lockout_tb passed");
		else
			$display("run_mode_sequencer_with_fault_lockout_tb failed");
		$finish;
	end

	// hang guard
	initial begin
		#1_000_000;
		$display("run_mode_sequencer_with_fault_lockout_tb failed");
		$finish;
	end

endmodule
